// ===== sv/pptsch_pkg.sv =====
`timescale 1ns / 1ps
// Package for the priority periodic task scheduler.
// Holds the shared types, codes and defaults; depends on nothing.
package pptsch_pkg;

  localparam int MAX_TASKS_DEF  = 16;
  localparam int FIFO_DEPTH_DEF = 2;
  localparam int ID_W           = 8;
  localparam int PRIO_W         = 8;
  localparam int TIME_W         = 16;
  localparam int CMD_W          = 3;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_SUSPEND = 3'd2,
    OP_RESUME  = 3'd3,
    OP_DELETE  = 3'd4,
    OP_NOP     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } sched_state_e;

  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   target;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] first_delay;
  } cmd_t;

  typedef struct packed {
    status_e         status;
    logic            run_valid;
    logic [ID_W-1:0] id;
  } result_t;

  typedef struct packed {
    logic              ready;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] delay;
  } entry_t;

  function automatic op_e decode_cmd(input logic [CMD_W-1:0] code);
    op_e op;
    case (code)
      3'd0:    op = OP_TICK;
      3'd1:    op = OP_CREATE;
      3'd2:    op = OP_SUSPEND;
      3'd3:    op = OP_RESUME;
      3'd4:    op = OP_DELETE;
      default: op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

// ===== sv/pptsch_fifo.sv =====
`timescale 1ns / 1ps
// Small register FIFO used for the command and result queues.
// Standalone; no package dependency.
module pptsch_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_full_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_empty_o,
  input  logic             rd_pop_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign wr_full_o  = (cnt_q == CW'(DEPTH));
  assign rd_empty_o = (cnt_q == '0);
  assign do_wr      = wr_valid_i && !wr_full_o;
  assign do_rd      = rd_pop_i && !rd_empty_o;
  assign rd_data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== sv/pptsch_front.sv =====
`timescale 1ns / 1ps
// Front end: decodes incoming command words and queues them for the engine.
// Depends on pptsch_pkg and pptsch_fifo.
module pptsch_front #(
  parameter int FIFO_DEPTH = pptsch_pkg::FIFO_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [pptsch_pkg::CMD_W-1:0]    command_i,
  input  logic [pptsch_pkg::ID_W-1:0]     target_id_i,
  input  logic [pptsch_pkg::PRIO_W-1:0]   new_priority_i,
  input  logic [pptsch_pkg::TIME_W-1:0]   new_period_i,
  input  logic [pptsch_pkg::TIME_W-1:0]   new_first_delay_i,
  output logic                            cmd_valid_o,
  input  logic                            cmd_pop_i,
  output pptsch_pkg::cmd_t                cmd_o
);

  pptsch_pkg::cmd_t cmd_in;
  logic             cmd_empty;

  always_comb begin
    cmd_in.op          = pptsch_pkg::decode_cmd(command_i);
    cmd_in.target      = target_id_i;
    cmd_in.prio        = new_priority_i;
    cmd_in.period      = new_period_i;
    cmd_in.first_delay = new_first_delay_i;
  end

  pptsch_fifo #(
    .WIDTH($bits(pptsch_pkg::cmd_t)),
    .DEPTH(FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push),
    .wr_full_o  (full),
    .wr_data_i  (cmd_in),
    .rd_empty_o (cmd_empty),
    .rd_pop_i   (cmd_pop_i),
    .rd_data_o  (cmd_o)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

// ===== sv/pptsch_engine.sv =====
`timescale 1ns / 1ps
// Back end: executes one command at a time by walking the task memory.
// Depends on pptsch_pkg.
module pptsch_engine #(
  parameter int MAX_TASKS = pptsch_pkg::MAX_TASKS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  input  pptsch_pkg::cmd_t    cmd_i,
  input  logic                res_full_i,
  output logic                res_push_o,
  output pptsch_pkg::result_t res_o
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int NW = pptsch_pkg::ID_W + 1;

  pptsch_pkg::entry_t mem [MAX_TASKS];

  pptsch_pkg::sched_state_e          state_q, state_d;
  pptsch_pkg::cmd_t                  cmd_q, cmd_d;
  pptsch_pkg::result_t               res_q, res_d;
  pptsch_pkg::entry_t                rdata_q, wr_data;
  logic                              rvalid_q;
  logic [CW-1:0]                     iss_q, iss_d;
  logic                              proc_v_q, proc_v_d;
  logic [IW-1:0]                     proc_idx_q, proc_idx_d;
  logic                              best_found_q, best_found_d;
  logic [IW-1:0]                     best_idx_q, best_idx_d;
  logic [pptsch_pkg::PRIO_W-1:0]     best_pri_q, best_pri_d;
  logic [pptsch_pkg::ID_W-1:0]       best_id_q, best_id_d;
  logic [pptsch_pkg::TIME_W-1:0]     best_per_q, best_per_d;
  logic [NW-1:0]                     next_id_q, next_id_d;
  logic [MAX_TASKS-1:0]              valid_q, valid_d;
  logic                              rd_en, we;
  logic [IW-1:0]                     rd_addr, wr_addr;

  always_comb begin
    pptsch_pkg::entry_t e;
    logic               better;
    e            = rdata_q;
    better       = 1'b0;
    state_d      = state_q;
    cmd_d        = cmd_q;
    res_d        = res_q;
    iss_d        = iss_q;
    proc_v_d     = 1'b0;
    proc_idx_d   = proc_idx_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_pri_d   = best_pri_q;
    best_id_d    = best_id_q;
    best_per_d   = best_per_q;
    next_id_d    = next_id_q;
    valid_d      = valid_q;
    rd_en        = 1'b0;
    rd_addr      = iss_q[IW-1:0];
    we           = 1'b0;
    wr_addr      = proc_idx_q;
    wr_data      = rdata_q;
    cmd_pop_o    = 1'b0;
    res_push_o   = 1'b0;
    case (state_q)
      pptsch_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o     = 1'b1;
          cmd_d         = cmd_i;
          iss_d         = '0;
          best_found_d  = 1'b0;
          res_d.status    = pptsch_pkg::STAT_OK;
          res_d.run_valid = 1'b0;
          res_d.id        = '0;
          case (cmd_i.op)
            pptsch_pkg::OP_TICK: begin
              state_d = pptsch_pkg::S_WALK;
            end
            pptsch_pkg::OP_CREATE: begin
              if (next_id_q[NW-1]) begin
                res_d.status = pptsch_pkg::STAT_FULL;
                state_d      = pptsch_pkg::S_FINISH;
              end else begin
                state_d = pptsch_pkg::S_WALK;
              end
            end
            pptsch_pkg::OP_SUSPEND, pptsch_pkg::OP_RESUME, pptsch_pkg::OP_DELETE: begin
              if ({1'b0, cmd_i.target} >= next_id_q) begin
                res_d.status = pptsch_pkg::STAT_NOTFOUND;
                state_d      = pptsch_pkg::S_FINISH;
              end else begin
                state_d = pptsch_pkg::S_WALK;
              end
            end
            default: begin
              state_d = pptsch_pkg::S_FINISH;
            end
          endcase
        end
      end
      pptsch_pkg::S_WALK: begin
        if (iss_q < CW'(MAX_TASKS)) begin
          rd_en      = 1'b1;
          proc_v_d   = 1'b1;
          proc_idx_d = iss_q[IW-1:0];
          iss_d      = iss_q + 1'b1;
        end
        if (proc_v_q) begin
          case (cmd_q.op)
            pptsch_pkg::OP_TICK: begin
              better = !best_found_q || (e.prio > best_pri_q) ||
                       ((e.prio == best_pri_q) && (e.id > best_id_q));
              if (rvalid_q && e.ready && (e.delay == '0) && better) begin
                best_found_d = 1'b1;
                best_idx_d   = proc_idx_q;
                best_pri_d   = e.prio;
                best_id_d    = e.id;
                best_per_d   = e.period;
              end
              if (rvalid_q && e.ready && (e.delay != '0)) begin
                we            = 1'b1;
                wr_data       = e;
                wr_data.delay = e.delay - 1'b1;
              end
            end
            pptsch_pkg::OP_CREATE: begin
              if (!rvalid_q) begin
                we                  = 1'b1;
                wr_data.ready       = 1'b1;
                wr_data.id          = next_id_q[pptsch_pkg::ID_W-1:0];
                wr_data.prio        = cmd_q.prio;
                wr_data.period      = cmd_q.period;
                wr_data.delay       = cmd_q.first_delay;
                valid_d[proc_idx_q] = 1'b1;
                res_d.id            = next_id_q[pptsch_pkg::ID_W-1:0];
                next_id_d           = next_id_q + 1'b1;
                state_d             = pptsch_pkg::S_FINISH;
              end
            end
            pptsch_pkg::OP_SUSPEND, pptsch_pkg::OP_RESUME, pptsch_pkg::OP_DELETE: begin
              if (rvalid_q && (e.id == cmd_q.target)) begin
                if (cmd_q.op == pptsch_pkg::OP_DELETE) begin
                  valid_d[proc_idx_q] = 1'b0;
                end else begin
                  we            = 1'b1;
                  wr_data       = e;
                  wr_data.ready = (cmd_q.op == pptsch_pkg::OP_RESUME);
                end
                state_d = pptsch_pkg::S_FINISH;
              end
            end
            default: begin
              state_d = pptsch_pkg::S_FINISH;
            end
          endcase
        end else if (iss_q == CW'(MAX_TASKS)) begin
          case (cmd_q.op)
            pptsch_pkg::OP_TICK: begin
              if (best_found_q) begin
                res_d.run_valid = 1'b1;
                res_d.id        = best_id_q;
              end
            end
            pptsch_pkg::OP_CREATE: begin
              res_d.status = pptsch_pkg::STAT_FULL;
            end
            default: begin
              res_d.status = pptsch_pkg::STAT_NOTFOUND;
            end
          endcase
          state_d = pptsch_pkg::S_FINISH;
        end
      end
      pptsch_pkg::S_FINISH: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = pptsch_pkg::S_IDLE;
          if ((cmd_q.op == pptsch_pkg::OP_TICK) && best_found_q) begin
            we             = 1'b1;
            wr_addr        = best_idx_q;
            wr_data.ready  = 1'b1;
            wr_data.id     = best_id_q;
            wr_data.prio   = best_pri_q;
            wr_data.period = best_per_q;
            wr_data.delay  = (best_per_q == '0) ? '0 : best_per_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = pptsch_pkg::S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pptsch_pkg::S_IDLE;
      proc_v_q  <= 1'b0;
      next_id_q <= '0;
      valid_q   <= '0;
    end else begin
      state_q   <= state_d;
      proc_v_q  <= proc_v_d;
      next_id_q <= next_id_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    res_q        <= res_d;
    iss_q        <= iss_d;
    proc_idx_q   <= proc_idx_d;
    best_found_q <= best_found_d;
    best_idx_q   <= best_idx_d;
    best_pri_q   <= best_pri_d;
    best_id_q    <= best_id_d;
    best_per_q   <= best_per_d;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q  <= mem[rd_addr];
      rvalid_q <= valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ===== sv/priority_periodic_task_scheduler_top.sv =====
`timescale 1ns / 1ps
// Each command word enters a small queue and is then executed by the engine,
// which walks the task memory through its single read port, one entry per
// cycle. A word reaches the engine once the queue has registered it. A tick,
// and a create, suspend, resume or delete that finds no match, walks all
// MAX_TASKS entries; a create or lookup that matches at entry k stops there;
// rejected or unknown commands skip the walk. Results are queued on the output
// side, so up to FIFO_DEPTH waiting results do not stop new commands.

// Top level of the priority periodic task scheduler.
// Depends on pptsch_pkg, pptsch_fifo, pptsch_front and pptsch_engine.
module priority_periodic_task_scheduler_top #(
  parameter int MAX_TASKS  = pptsch_pkg::MAX_TASKS_DEF,
  parameter int FIFO_DEPTH = pptsch_pkg::FIFO_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [pptsch_pkg::CMD_W-1:0]  command_i,
  input  logic [pptsch_pkg::ID_W-1:0]   target_id_i,
  input  logic [pptsch_pkg::PRIO_W-1:0] new_priority_i,
  input  logic [pptsch_pkg::TIME_W-1:0] new_period_i,
  input  logic [pptsch_pkg::TIME_W-1:0] new_first_delay_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    status_o,
  output logic                          run_valid_o,
  output logic [pptsch_pkg::ID_W-1:0]   result_id_o
);

  logic                cmd_valid, cmd_pop, res_push, res_full;
  pptsch_pkg::cmd_t    cmd;
  pptsch_pkg::result_t res_in, res_out;

  pptsch_front #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .command_i         (command_i),
    .target_id_i       (target_id_i),
    .new_priority_i    (new_priority_i),
    .new_period_i      (new_period_i),
    .new_first_delay_i (new_first_delay_i),
    .cmd_valid_o       (cmd_valid),
    .cmd_pop_i         (cmd_pop),
    .cmd_o             (cmd)
  );

  pptsch_engine #(
    .MAX_TASKS(MAX_TASKS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  pptsch_fifo #(
    .WIDTH($bits(pptsch_pkg::result_t)),
    .DEPTH(FIFO_DEPTH)
  ) u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (res_push),
    .wr_full_o  (res_full),
    .wr_data_i  (res_in),
    .rd_empty_o (empty),
    .rd_pop_i   (pop),
    .rd_data_o  (res_out)
  );

  assign status_o    = res_out.status;
  assign run_valid_o = res_out.run_valid;
  assign result_id_o = res_out.id;

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push && res_full))
    else $error("engine pushed a result into a full result queue");

  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("engine took a command from an empty command queue");

  a_run_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && run_valid_o) |-> (res_out.status == pptsch_pkg::STAT_OK))
    else $error("a result that runs a task carries a failure status");

  a_one_result_per_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !res_push)
    else $error("a result was produced in the same cycle as a command was taken");
`endif

endmodule

// ===== sim/priority_periodic_task_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for priority_periodic_task_scheduler_top.
// Depends on pptsch_pkg; drives directed and random command words and checks each
// result word against a task table that the bench keeps on its own.
module priority_periodic_task_scheduler_top_tb;

  localparam int SLOTS = pptsch_pkg::MAX_TASKS_DEF;
  localparam int ID_LIMIT = 256;
  localparam int RANDOM_WORDS = 1680;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4 * (SLOTS + 4) + 10;

  typedef logic [pptsch_pkg::CMD_W-1:0]  code_t;
  typedef logic [pptsch_pkg::ID_W-1:0]   tid_t;
  typedef logic [pptsch_pkg::PRIO_W-1:0] prio_t;
  typedef logic [pptsch_pkg::TIME_W-1:0] ticks_t;

  typedef struct {
    code_t  code;
    tid_t   target;
    prio_t  prio;
    ticks_t period;
    ticks_t first_delay;
  } sched_word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  code_t               command_i;
  tid_t                target_id_i;
  prio_t               new_priority_i;
  ticks_t              new_period_i;
  ticks_t              new_first_delay_i;
  logic                empty;
  logic                pop;
  logic [1:0]          status_o;
  logic                run_valid_o;
  tid_t                result_id_o;

  priority_periodic_task_scheduler_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .command_i         (command_i),
    .target_id_i       (target_id_i),
    .new_priority_i    (new_priority_i),
    .new_period_i      (new_period_i),
    .new_first_delay_i (new_first_delay_i),
    .empty             (empty),
    .pop               (pop),
    .status_o          (status_o),
    .run_valid_o       (run_valid_o),
    .result_id_o       (result_id_o)
  );

  // Shadow copy of the task table.
  logic              task_live   [SLOTS];
  logic              task_awake  [SLOTS];
  tid_t              task_id     [SLOTS];
  prio_t             task_prio   [SLOTS];
  ticks_t            task_period [SLOTS];
  ticks_t            task_delay  [SLOTS];
  logic [8:0]        next_id;

  sched_word_t         cmd_backlog[$];
  pptsch_pkg::result_t sched_results_due[$];

  bit push_fire;
  bit pop_fire;
  bit steady_send;
  bit steady_take;
  int send_gap;
  int take_gap;
  int idle_cycles;
  int errors;
  int words_made;
  int words_in;
  int runs_seen;
  int creates_ok;
  int creates_refused;
  int lookups_missed;

  function automatic pptsch_pkg::result_t schedule_outcome(input sched_word_t w);
    pptsch_pkg::result_t r;
    int best;
    int slot;
    r.status = pptsch_pkg::STAT_OK;
    r.run_valid = 1'b0;
    r.id = '0;
    best = -1;
    slot = -1;
    case (w.code)
      pptsch_pkg::OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (task_live[i] && task_awake[i] && task_delay[i] == '0 &&
              (best < 0 || task_prio[i] > task_prio[best] ||
               (task_prio[i] == task_prio[best] && task_id[i] > task_id[best]))) begin
            best = i;
          end
        end
        if (best >= 0) begin
          task_delay[best] = task_period[best];
          r.run_valid = 1'b1;
          r.id = task_id[best];
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (task_live[i] && task_awake[i] && task_delay[i] != '0) begin
            task_delay[i] = task_delay[i] - 1'b1;
          end
        end
      end
      pptsch_pkg::OP_CREATE: begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!task_live[i]) slot = i;
        end
        if (slot < 0 || next_id >= ID_LIMIT) begin
          r.status = pptsch_pkg::STAT_FULL;
        end else begin
          task_live[slot] = 1'b1;
          task_awake[slot] = 1'b1;
          task_id[slot] = next_id[pptsch_pkg::ID_W-1:0];
          task_prio[slot] = w.prio;
          task_period[slot] = w.period;
          task_delay[slot] = w.first_delay;
          r.id = next_id[pptsch_pkg::ID_W-1:0];
          next_id = next_id + 1'b1;
        end
      end
      pptsch_pkg::OP_SUSPEND, pptsch_pkg::OP_RESUME, pptsch_pkg::OP_DELETE: begin
        if (w.target < next_id) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (task_live[i] && task_id[i] == w.target) slot = i;
          end
        end
        if (slot < 0) begin
          r.status = pptsch_pkg::STAT_NOTFOUND;
        end else if (w.code == pptsch_pkg::OP_SUSPEND) begin
          task_awake[slot] = 1'b0;
        end else if (w.code == pptsch_pkg::OP_RESUME) begin
          task_awake[slot] = 1'b1;
        end else begin
          task_live[slot] = 1'b0;
          task_awake[slot] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_word(input code_t code, input tid_t target,
                          input prio_t prio, input ticks_t period,
                          input ticks_t first_delay);
    sched_word_t w;
    w.code = code;
    w.target = target;
    w.prio = prio;
    w.period = period;
    w.first_delay = first_delay;
    cmd_backlog.push_back(w);
    words_made++;
  endtask

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    sched_word_t w;
    if (rst_ni && (!push || push_fire)) begin
      if (send_gap > 0) begin
        push <= 1'b0;
        send_gap--;
      end else if (cmd_backlog.size() > 0) begin
        w = cmd_backlog.pop_front();
        command_i <= w.code;
        target_id_i <= w.target;
        new_priority_i <= w.prio;
        new_period_i <= w.period;
        new_first_delay_i <= w.first_delay;
        push <= 1'b1;
        send_gap = steady_send ? 0 : int'($urandom_range(0, 4));
        if ($urandom_range(0, 49) == 0) steady_send = !steady_send;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!pop || pop_fire)) begin
      if (pop_fire) begin
        take_gap = steady_take ? 0 : int'($urandom_range(0, 4));
        if ($urandom_range(0, 49) == 0) steady_take = !steady_take;
      end
      if (take_gap > 0) begin
        pop <= 1'b0;
        take_gap--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    sched_word_t w;
    pptsch_pkg::result_t want;
    push_fire = push && !full;
    pop_fire = pop && !empty;
    if (rst_ni) begin
      if (push_fire) begin
        w.code = command_i;
        w.target = target_id_i;
        w.prio = new_priority_i;
        w.period = new_period_i;
        w.first_delay = new_first_delay_i;
        want = schedule_outcome(w);
        sched_results_due.push_back(want);
        words_in++;
        if (want.run_valid) runs_seen++;
        if (w.code == pptsch_pkg::OP_CREATE && want.status == pptsch_pkg::STAT_OK) begin
          creates_ok++;
        end
        if (want.status == pptsch_pkg::STAT_FULL) creates_refused++;
        if (want.status == pptsch_pkg::STAT_NOTFOUND) lookups_missed++;
      end
      if (pop_fire) begin
        if (sched_results_due.size() == 0) begin
          $display("%0t: unexpected result word status=%0d run_valid=%0d id=%0d",
                   $time, status_o, run_valid_o, result_id_o);
          errors++;
        end else begin
          want = sched_results_due.pop_front();
          if (status_o !== want.status || run_valid_o !== want.run_valid ||
              result_id_o !== want.id) begin
            $display("%0t: expected status=%0d run_valid=%0d id=%0d, got %0d %0d %0d",
                     $time, want.status, want.run_valid, want.id,
                     status_o, run_valid_o, result_id_o);
            errors++;
          end
        end
      end
      if (push_fire || pop_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, sched_results_due.size());
        $display("FAIL priority_periodic_task_scheduler_top");
        $finish;
      end
    end
  end

  initial begin
    sched_word_t w;
    int roll;
    int pick;
    bit churn;
    tid_t live_ids[$];

    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    command_i = '0;
    target_id_i = '0;
    new_priority_i = '0;
    new_period_i = '0;
    new_first_delay_i = '0;
    for (int i = 0; i < SLOTS; i++) begin
      task_live[i] = 1'b0;
      task_awake[i] = 1'b0;
      task_id[i] = '0;
      task_prio[i] = '0;
      task_period[i] = '0;
      task_delay[i] = '0;
    end
    next_id = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: empty table, zero period, priority ties and bad targets.
    add_word(pptsch_pkg::OP_TICK, '0, '0, '0, '0);
    add_word(pptsch_pkg::OP_SUSPEND, '0, '0, '0, '0);
    add_word(pptsch_pkg::OP_CREATE, '1, '1, '0, '0);
    add_word(pptsch_pkg::OP_CREATE, '0, '1, '1, '0);
    add_word(pptsch_pkg::OP_TICK, '1, '1, '1, '1);
    add_word(pptsch_pkg::OP_TICK, '0, '0, '0, '0);
    add_word(pptsch_pkg::OP_TICK, '0, '0, '0, '0);
    add_word(pptsch_pkg::OP_CREATE, '0, '0, 16'd1, '1);
    add_word(pptsch_pkg::OP_SUSPEND, 8'd0, '0, '0, '0);
    add_word(pptsch_pkg::OP_SUSPEND, 8'd0, '0, '0, '0);
    add_word(pptsch_pkg::OP_TICK, '0, '0, '0, '0);
    add_word(pptsch_pkg::OP_RESUME, 8'd0, '0, '0, '0);
    add_word(pptsch_pkg::OP_RESUME, 8'd0, '0, '0, '0);
    add_word(pptsch_pkg::OP_DELETE, 8'd1, '0, '0, '0);
    add_word(pptsch_pkg::OP_DELETE, 8'd1, '0, '0, '0);
    add_word(pptsch_pkg::OP_RESUME, 8'd3, '0, '0, '0);
    add_word(pptsch_pkg::OP_SUSPEND, '1, '1, '1, '1);
    add_word(pptsch_pkg::OP_DELETE, 8'd0, '0, '0, '0);
    for (int k = pptsch_pkg::OP_DELETE + 1; k <= pptsch_pkg::OP_NOP; k++) begin
      add_word(code_t'(k), '1, '1, '1, '1);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      while (cmd_backlog.size() >= 2) @(posedge clk_i);
      churn = (n >= RANDOM_WORDS * 2 / 3);
      roll = $urandom_range(0, 99);
      w.target = tid_t'($urandom);
      w.prio = prio_t'($urandom);
      w.period = ticks_t'($urandom);
      w.first_delay = ticks_t'($urandom);
      if (roll < (churn ? 20 : 40)) begin
        w.code = pptsch_pkg::OP_TICK;
      end else if (roll < (churn ? 55 : 60)) begin
        w.code = pptsch_pkg::OP_CREATE;
        if ($urandom_range(0, 1) == 0) w.prio = prio_t'($urandom_range(0, 3));
        if ($urandom_range(0, 9) != 0) begin
          w.period = ticks_t'($urandom_range(0, 7));
          w.first_delay = ticks_t'($urandom_range(0, 7));
        end
      end else if (roll < (churn ? 95 : 94)) begin
        if (roll < (churn ? 60 : 70)) w.code = pptsch_pkg::OP_SUSPEND;
        else if (roll < (churn ? 65 : 80)) w.code = pptsch_pkg::OP_RESUME;
        else w.code = pptsch_pkg::OP_DELETE;
        live_ids.delete();
        for (int i = 0; i < SLOTS; i++) begin
          if (task_live[i]) live_ids.push_back(task_id[i]);
        end
        pick = $urandom_range(0, 9);
        if (pick < 8 && live_ids.size() > 0) begin
          w.target = live_ids[$urandom_range(0, live_ids.size() - 1)];
        end else if (pick == 8) begin
          w.target = next_id[pptsch_pkg::ID_W-1:0];
        end
      end else begin
        w.code = code_t'($urandom_range(pptsch_pkg::OP_NOP, pptsch_pkg::OP_DELETE + 1));
      end
      add_word(w.code, w.target, w.prio, w.period, w.first_delay);
    end

    while (words_in < words_made) @(posedge clk_i);
    while (sched_results_due.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d command words; %0d task runs, %0d creates accepted, %0d refused,",
             words_in, runs_seen, creates_ok, creates_refused);
    $display("%0d lookups missed, %0d ids handed out, %0d mismatches.",
             lookups_missed, next_id, errors);
    if (errors == 0) begin
      $display("PASS priority_periodic_task_scheduler_top");
    end else begin
      $display("FAIL priority_periodic_task_scheduler_top");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pptsch_pkg.sv
sv/pptsch_fifo.sv
sv/pptsch_front.sv
sv/pptsch_engine.sv
sv/priority_periodic_task_scheduler_top.sv
sim/priority_periodic_task_scheduler_top_tb.sv
